// ----- src/mfat_pkg.sv -----
`timescale 1ns / 1ps
// Package: constants, widths and the tracker record shared by the angle tracker modules.
package mfat_pkg;

  localparam int NUM_MOTORS = 11;
  localparam int BASE_ID    = 513;

  localparam int ID_W    = 11;
  localparam int BYTE_W  = 8;
  localparam int MOTOR_W = 4;
  localparam int ANGLE_W = 16;
  localparam int WORD_W  = 32;
  localparam int DEG_W   = 10;

  localparam int DIFF_W = ANGLE_W + 2;
  localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(4096);
  localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(8192);

  // 36 * 8192 = 9 << 15; a remainder by it is a remainder by nine of the high part
  localparam int SHAFT_SHIFT = 15;
  localparam int HI_W        = WORD_W - SHAFT_SHIFT;
  localparam int DIV9_SHIFT  = 20;
  localparam logic [HI_W-1:0] DIV9_MULT = HI_W'(116509);
  localparam logic [HI_W-1:0] NINE      = HI_W'(9);
  localparam int PROD_W      = 2 * HI_W;
  localparam int Q_W         = PROD_W - DIV9_SHIFT;
  localparam int DIGIT_W     = 4;

  // 360 / 294912 = 10 / 8192
  localparam int REM_W    = DIGIT_W + SHAFT_SHIFT;
  localparam int SCALED_W = REM_W + 4;
  localparam int DEG_SHIFT = 13;
  localparam logic [SCALED_W-1:0] DEG_NUM = SCALED_W'(10);

  typedef struct packed {
    logic [MOTOR_W-1:0]       motor_index;
    logic [ANGLE_W-1:0]       rotor_angle;
    logic signed [ANGLE_W-1:0] rotor_speed;
    logic [ANGLE_W-1:0]       motor_current;
    logic [BYTE_W-1:0]        temperature;
    logic signed [WORD_W-1:0] turn_count;
    logic signed [WORD_W-1:0] accumulated_angle;
  } fb_t;

endpackage

// ----- src/mfat_track.sv -----
`timescale 1ns / 1ps
// Frame input register, per-motor multi-turn state and tracker result register.
module mfat_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         frame_valid,
  output logic                         frame_stall,
  input  logic [mfat_pkg::ID_W-1:0]    frame_id,
  input  logic [mfat_pkg::BYTE_W-1:0]  byte0,
  input  logic [mfat_pkg::BYTE_W-1:0]  byte1,
  input  logic [mfat_pkg::BYTE_W-1:0]  byte2,
  input  logic [mfat_pkg::BYTE_W-1:0]  byte3,
  input  logic [mfat_pkg::BYTE_W-1:0]  byte4,
  input  logic [mfat_pkg::BYTE_W-1:0]  byte5,
  input  logic [mfat_pkg::BYTE_W-1:0]  byte6,
  output logic                         fb_valid,
  input  logic                         fb_stall,
  output mfat_pkg::fb_t                fb
);

  logic                             in_vld;
  logic [mfat_pkg::ID_W-1:0]        id_q;
  logic [mfat_pkg::ANGLE_W-1:0]     ang_q;
  logic [mfat_pkg::ANGLE_W-1:0]     spd_q;
  logic [mfat_pkg::ANGLE_W-1:0]     cur_q;
  logic [mfat_pkg::BYTE_W-1:0]      temp_q;

  logic [mfat_pkg::ANGLE_W-1:0]       prev_angle [mfat_pkg::NUM_MOTORS];
  logic signed [mfat_pkg::WORD_W-1:0] turn_cnt   [mfat_pkg::NUM_MOTORS];
  logic signed [mfat_pkg::WORD_W-1:0] total      [mfat_pkg::NUM_MOTORS];

  logic                               adv;
  logic                               hit;
  logic [mfat_pkg::MOTOR_W-1:0]       idx;
  logic [mfat_pkg::ANGLE_W-1:0]       prev;
  logic signed [mfat_pkg::DIFF_W-1:0] d;
  logic signed [mfat_pkg::DIFF_W-1:0] delta;
  logic                               fwd;
  logic                               back;
  logic signed [mfat_pkg::WORD_W-1:0] turn_next;
  logic signed [mfat_pkg::WORD_W-1:0] total_next;

  assign adv         = !fb_valid || !fb_stall;
  assign frame_stall = in_vld && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!frame_stall) begin
      in_vld <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!frame_stall && frame_valid) begin
      id_q   <= frame_id;
      ang_q  <= {byte0, byte1};
      spd_q  <= {byte2, byte3};
      cur_q  <= {byte4, byte5};
      temp_q <= byte6;
    end
  end

  always_comb begin
    hit  = (id_q >= mfat_pkg::ID_W'(mfat_pkg::BASE_ID)) &&
           (id_q < mfat_pkg::ID_W'(mfat_pkg::BASE_ID + mfat_pkg::NUM_MOTORS));
    idx  = mfat_pkg::MOTOR_W'(id_q - mfat_pkg::ID_W'(mfat_pkg::BASE_ID));
    prev = prev_angle[idx];
    d    = signed'(mfat_pkg::DIFF_W'(ang_q)) - signed'(mfat_pkg::DIFF_W'(prev));
    fwd  = d > mfat_pkg::HALF_TURN;
    back = d < -mfat_pkg::HALF_TURN;
    priority if (fwd) begin
      delta     = d - mfat_pkg::FULL_TURN;
      turn_next = turn_cnt[idx] - mfat_pkg::WORD_W'(1);
    end else if (back) begin
      delta     = d + mfat_pkg::FULL_TURN;
      turn_next = turn_cnt[idx] + mfat_pkg::WORD_W'(1);
    end else begin
      delta     = d;
      turn_next = turn_cnt[idx];
    end
    total_next = total[idx] + mfat_pkg::WORD_W'(delta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < mfat_pkg::NUM_MOTORS; k++) begin
        prev_angle[k] <= '0;
        turn_cnt[k]   <= '0;
        total[k]      <= '0;
      end
    end else if (in_vld && hit && adv) begin
      prev_angle[idx] <= ang_q;
      turn_cnt[idx]   <= turn_next;
      total[idx]      <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fb_valid <= 1'b0;
    end else if (adv) begin
      fb_valid <= in_vld && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fb.motor_index       <= idx;
      fb.rotor_angle       <= ang_q;
      fb.rotor_speed       <= signed'(spd_q);
      fb.motor_current     <= cur_q;
      fb.temperature       <= temp_q;
      fb.turn_count        <= turn_next;
      fb.accumulated_angle <= total_next;
    end
  end

endmodule

// ----- src/mfat_deg.sv -----
`timescale 1ns / 1ps
// Output shaft degree pipeline and result register.
module mfat_deg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             fb_valid,
  output logic                             fb_stall,
  input  mfat_pkg::fb_t                    fb,
  output logic                             res_valid,
  input  logic                             res_stall,
  output mfat_pkg::fb_t                    res,
  output logic signed [mfat_pkg::DEG_W-1:0] res_deg
);

  logic                              v1;
  logic                              v2;
  logic                              adv1;
  logic                              adv2;
  logic                              adv3;
  mfat_pkg::fb_t                     r1;
  mfat_pkg::fb_t                     r2;
  logic                              neg1;
  logic                              neg2;
  logic [mfat_pkg::WORD_W-1:0]       mag1;
  logic [mfat_pkg::SHAFT_SHIFT-1:0]  lo2;
  logic [mfat_pkg::HI_W-1:0]         hi2;
  logic [mfat_pkg::PROD_W-1:0]       prod2;

  logic [mfat_pkg::WORD_W-1:0]       mag_c;
  logic [mfat_pkg::HI_W-1:0]         hi1;
  logic [mfat_pkg::Q_W-1:0]          q;
  logic [mfat_pkg::HI_W-1:0]         rem_hi;
  logic [mfat_pkg::REM_W-1:0]        rem;
  logic [mfat_pkg::SCALED_W-1:0]     scaled;
  logic [mfat_pkg::DEG_W-1:0]        deg_mag;
  logic signed [mfat_pkg::DEG_W-1:0] deg_c;

  assign adv3     = !res_valid || !res_stall;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign fb_stall = !adv1;

  always_comb begin
    mag_c   = fb.accumulated_angle[mfat_pkg::WORD_W-1] ?
              mfat_pkg::WORD_W'(-fb.accumulated_angle) :
              mfat_pkg::WORD_W'(fb.accumulated_angle);
    hi1     = mag1[mfat_pkg::WORD_W-1:mfat_pkg::SHAFT_SHIFT];
    q       = prod2[mfat_pkg::PROD_W-1:mfat_pkg::DIV9_SHIFT];
    rem_hi  = hi2 - mfat_pkg::HI_W'(q) * mfat_pkg::NINE;
    rem     = {rem_hi[mfat_pkg::DIGIT_W-1:0], lo2};
    scaled  = mfat_pkg::SCALED_W'(rem) * mfat_pkg::DEG_NUM;
    deg_mag = scaled[mfat_pkg::SCALED_W-1:mfat_pkg::DEG_SHIFT];
    deg_c   = neg2 ? signed'(mfat_pkg::DEG_W'(-deg_mag)) : signed'(deg_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= fb_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        res_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      r1   <= fb;
      neg1 <= fb.accumulated_angle[mfat_pkg::WORD_W-1];
      mag1 <= mag_c;
    end
    if (adv2) begin
      r2    <= r1;
      neg2  <= neg1;
      lo2   <= mag1[mfat_pkg::SHAFT_SHIFT-1:0];
      hi2   <= hi1;
      prod2 <= mfat_pkg::PROD_W'(hi1) * mfat_pkg::PROD_W'(mfat_pkg::DIV9_MULT);
    end
    if (adv3) begin
      res     <= r2;
      res_deg <= deg_c;
    end
  end

endmodule

// ----- src/motor_feedback_angle_tracker_core.sv -----
`timescale 1ns / 1ps
// Top level of the motor feedback multi-turn angle tracker.
//
//  channel  | handshake                  | payload
//  frame    | frame_valid / frame_stall  | frame_id, byte0 .. byte6
//  result   | result_valid / result_stall| motor_index .. shaft_degrees
//
// One frame is taken every cycle while frame_stall is low.
// Frames outside the motor identifier window are dropped after the input register.
// Per-motor state sits in flip-flops, so a frame sees the update of the one before it.
// Reset clears all motor state and every valid flag.
// A stalled result holds the pipeline stage by stage; bubbles close up behind it.
module motor_feedback_angle_tracker_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  output logic                             frame_stall,
  input  logic [mfat_pkg::ID_W-1:0]        frame_id,
  input  logic [mfat_pkg::BYTE_W-1:0]      byte0,
  input  logic [mfat_pkg::BYTE_W-1:0]      byte1,
  input  logic [mfat_pkg::BYTE_W-1:0]      byte2,
  input  logic [mfat_pkg::BYTE_W-1:0]      byte3,
  input  logic [mfat_pkg::BYTE_W-1:0]      byte4,
  input  logic [mfat_pkg::BYTE_W-1:0]      byte5,
  input  logic [mfat_pkg::BYTE_W-1:0]      byte6,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [mfat_pkg::MOTOR_W-1:0]     motor_index,
  output logic [mfat_pkg::ANGLE_W-1:0]     rotor_angle,
  output logic signed [mfat_pkg::ANGLE_W-1:0] rotor_speed,
  output logic [mfat_pkg::ANGLE_W-1:0]     motor_current,
  output logic [mfat_pkg::BYTE_W-1:0]      temperature,
  output logic signed [mfat_pkg::WORD_W-1:0] turn_count,
  output logic signed [mfat_pkg::WORD_W-1:0] accumulated_angle,
  output logic signed [mfat_pkg::DEG_W-1:0]  shaft_degrees
);

  logic          fb_valid;
  logic          fb_stall;
  mfat_pkg::fb_t fb;
  mfat_pkg::fb_t res;

  mfat_track u_track (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame_id    (frame_id),
    .byte0       (byte0),
    .byte1       (byte1),
    .byte2       (byte2),
    .byte3       (byte3),
    .byte4       (byte4),
    .byte5       (byte5),
    .byte6       (byte6),
    .fb_valid    (fb_valid),
    .fb_stall    (fb_stall),
    .fb          (fb)
  );

  mfat_deg u_deg (
    .clk       (clk),
    .rst       (rst),
    .fb_valid  (fb_valid),
    .fb_stall  (fb_stall),
    .fb        (fb),
    .res_valid (result_valid),
    .res_stall (result_stall),
    .res       (res),
    .res_deg   (shaft_degrees)
  );

  assign motor_index       = res.motor_index;
  assign rotor_angle       = res.rotor_angle;
  assign rotor_speed       = res.rotor_speed;
  assign motor_current     = res.motor_current;
  assign temperature       = res.temperature;
  assign turn_count        = res.turn_count;
  assign accumulated_angle = res.accumulated_angle;

endmodule
